// ===== sv/v4n_pkg.sv =====
// Shared constants, transaction types and control structs for vector4_normalize.
// No dependencies; every other file imports this package.
package v4n_pkg;

  localparam int COMPONENT_BITS = 16;
  localparam int UNIT_BITS      = 16;
  localparam int LANES          = 4;

  // the largest normalised magnitude lies in [2^29, 2^30]
  localparam int NORM_W        = 31;
  localparam int NORM_LOW_POS  = 29;
  localparam int NORM_HIGH_POS = 30;
  localparam int EXT_W   = (COMPONENT_BITS > NORM_W) ? COMPONENT_BITS : NORM_W;
  localparam int POS_W   = $clog2(COMPONENT_BITS);
  localparam int SHIFT_W = $clog2(NORM_LOW_POS + 1);

  localparam int SQ_W       = 2 * NORM_W - 1;
  localparam int PAIR_W     = SQ_W + 1;
  localparam int SUM_W      = SQ_W + 2;
  localparam int ROOT_STEPS = (SUM_W + 1) / 2;
  localparam int ROOT_W     = ROOT_STEPS;

  // reciprocal: floor((2^61 + floor(L/2)) / L)
  localparam int RECIP_NUM_POS  = 61;
  localparam int RECIP_W        = 33;
  localparam int RECIP_SEED_POS = RECIP_NUM_POS - RECIP_W;

  localparam int PROD_W    = NORM_W + RECIP_W;
  localparam int ROUND_POS = 46;
  localparam int U_W       = PROD_W - ROUND_POS;

  localparam logic [EXT_W-1:0]  NORM_HIGH  = EXT_W'(1) << NORM_HIGH_POS;
  localparam logic [ROOT_W-1:0] RECIP_SEED = ROOT_W'(1) << RECIP_SEED_POS;
  localparam logic [U_W-1:0]    U_MAX_NEG  = U_W'(1) << (UNIT_BITS - 1);
  localparam logic [U_W-1:0]    U_MAX_POS  = U_MAX_NEG - U_W'(1);

  typedef struct packed {
    logic signed [COMPONENT_BITS-1:0] comp_x;
    logic signed [COMPONENT_BITS-1:0] comp_y;
    logic signed [COMPONENT_BITS-1:0] comp_z;
    logic signed [COMPONENT_BITS-1:0] comp_w;
  } vec_in_t;

  typedef struct packed {
    logic signed [UNIT_BITS-1:0] unit_x;
    logic signed [UNIT_BITS-1:0] unit_y;
    logic signed [UNIT_BITS-1:0] unit_z;
    logic signed [UNIT_BITS-1:0] unit_w;
    logic                        zero_length;
  } vec_out_t;

  typedef struct packed {
    logic               right;
    logic [SHIFT_W-1:0] amt;
  } shift_ctrl_t;

  typedef struct packed {
    logic [LANES-1:0][NORM_W-1:0] mag;
    logic [LANES-1:0]             neg;
    logic                         zero;
  } meta_t;

endpackage

// ===== sv/v4n_lane_front.sv =====
// One component lane, front half: magnitude, common normalising shift, square.
// Depends on v4n_pkg; the shift control comes from v4n_merge.
module v4n_lane_front import v4n_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic [COMPONENT_BITS-1:0] comp,
  output logic [COMPONENT_BITS-1:0] mag,
  input  shift_ctrl_t               ctrl,
  output logic [NORM_W-1:0]         norm_mag,
  output logic                      neg,
  output logic [SQ_W-1:0]           square
);

  logic                      neg1, neg2, neg3;
  logic [COMPONENT_BITS-1:0] mag2;
  logic [NORM_W-1:0]         norm3;
  logic [EXT_W-1:0]          mag_ext;
  logic [NORM_W-1:0]         norm_next;
  logic [2*NORM_W-1:0]       sq_full;

  always_comb begin
    mag_ext   = EXT_W'(mag2);
    norm_next = ctrl.right ? NORM_W'(mag_ext >> 1) : NORM_W'(mag_ext << ctrl.amt);
    sq_full   = norm3 * norm3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1     <= comp[COMPONENT_BITS-1];
      mag      <= comp[COMPONENT_BITS-1] ? (~comp + COMPONENT_BITS'(1)) : comp;
      mag2     <= mag;
      neg2     <= neg1;
      norm3    <= norm_next;
      neg3     <= neg2;
      square   <= sq_full[SQ_W-1:0];
      norm_mag <= norm3;
      neg      <= neg3;
    end
  end

endmodule

// ===== sv/v4n_merge.sv =====
// Merge stage over the four lanes: common shift from the OR of magnitudes,
// zero detect, and the registered sum of squares. Depends on v4n_pkg.
module v4n_merge import v4n_pkg::*; (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  vec_valid,
  input  logic [LANES-1:0][COMPONENT_BITS-1:0]  mag,
  output shift_ctrl_t                           ctrl,
  input  logic [LANES-1:0][NORM_W-1:0]          norm_mag,
  input  logic [LANES-1:0]                      neg,
  input  logic [LANES-1:0][SQ_W-1:0]            square,
  output logic                                  sum_valid,
  output logic [SUM_W-1:0]                      sum,
  output meta_t                                 sum_meta
);

  logic [COMPONENT_BITS-1:0] mag_or;
  logic                      big;
  logic [POS_W-1:0]          lead;
  shift_ctrl_t               ctrl_next;
  logic                      zero2, zero3, zero4;
  logic [PAIR_W-1:0]         pair0, pair1;
  meta_t                     meta5;
  logic [5:0]                vld;

  always_comb begin
    mag_or = '0;
    big    = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      mag_or |= mag[i];
      big    |= (EXT_W'(mag[i]) > NORM_HIGH);
    end
    lead = '0;
    for (int b = 0; b < COMPONENT_BITS; b++) begin
      if (mag_or[b]) lead = b[POS_W-1:0];
    end
    ctrl_next.right = big;
    ctrl_next.amt   = (SHIFT_W'(lead) < SHIFT_W'(NORM_LOW_POS)) ?
                      SHIFT_W'(NORM_LOW_POS) - SHIFT_W'(lead) : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl           <= ctrl_next;
      zero2          <= (mag_or == '0);
      zero3          <= zero2;
      zero4          <= zero3;
      pair0          <= PAIR_W'(square[0]) + PAIR_W'(square[1]);
      pair1          <= PAIR_W'(square[2]) + PAIR_W'(square[3]);
      meta5.mag      <= norm_mag;
      meta5.neg      <= neg;
      meta5.zero     <= zero4;
      sum            <= SUM_W'(pair0) + SUM_W'(pair1);
      sum_meta       <= meta5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], vec_valid};
    end
  end

  assign sum_valid = vld[5];

endmodule

// ===== sv/v4n_isqrt.sv =====
// Pipelined rounded integer square root of the sum of squares, one result bit
// per stage plus a rounding stage. Depends on v4n_pkg.
module v4n_isqrt import v4n_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              sum_valid,
  input  logic [SUM_W-1:0]  sum,
  input  meta_t             sum_meta,
  output logic              len_valid,
  output logic [ROOT_W-1:0] len,
  output meta_t             len_meta
);

  logic [SUM_W-1:0] s_q   [1:ROOT_STEPS];
  logic [SUM_W-1:0] res_q [1:ROOT_STEPS];
  meta_t            meta_q [1:ROOT_STEPS];
  logic             vld_q [1:ROOT_STEPS];

  for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_step
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 1 - 2 * i);
    logic [SUM_W-1:0] s_cur, res_cur;
    meta_t            meta_cur;
    logic             vld_cur;
    logic [SUM_W:0]   trial;
    logic             take;

    if (i == 0) begin : g_head
      assign s_cur    = sum;
      assign res_cur  = '0;
      assign meta_cur = sum_meta;
      assign vld_cur  = sum_valid;
    end else begin : g_tail
      assign s_cur    = s_q[i];
      assign res_cur  = res_q[i];
      assign meta_cur = meta_q[i];
      assign vld_cur  = vld_q[i];
    end

    assign trial = {1'b0, res_cur} + {1'b0, BIT};
    assign take  = ({1'b0, s_cur} >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        s_q[i+1]    <= take ? (s_cur - trial[SUM_W-1:0]) : s_cur;
        res_q[i+1]  <= take ? ((res_cur >> 1) + BIT) : (res_cur >> 1);
        meta_q[i+1] <= meta_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i+1] <= 1'b0;
      end else if (en) begin
        vld_q[i+1] <= vld_cur;
      end
    end
  end

  // round to nearest: bump when remainder exceeds the root
  always_ff @(posedge clk) begin
    if (en) begin
      len      <= res_q[ROOT_STEPS][ROOT_W-1:0] +
                  ROOT_W'(s_q[ROOT_STEPS] > res_q[ROOT_STEPS]);
      len_meta <= meta_q[ROOT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_valid <= 1'b0;
    end else if (en) begin
      len_valid <= vld_q[ROOT_STEPS];
    end
  end

endmodule

// ===== sv/v4n_recip.sv =====
// Pipelined restoring divider for the rounded reciprocal of the length,
// one quotient bit per stage. Depends on v4n_pkg.
module v4n_recip import v4n_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               len_valid,
  input  logic [ROOT_W-1:0]  len,
  input  meta_t              len_meta,
  output logic               recip_valid,
  output logic [RECIP_W-1:0] recip,
  output meta_t              recip_meta
);

  logic [ROOT_W-1:0]  r_q    [1:RECIP_W-1];
  logic [ROOT_W-1:0]  l_q    [1:RECIP_W-1];
  logic [RECIP_W-1:0] q_q    [1:RECIP_W];
  meta_t              meta_q [1:RECIP_W];
  logic               vld_q  [1:RECIP_W];

  for (genvar n = 0; n < RECIP_W; n++) begin : g_step
    localparam int J = RECIP_W - 1 - n;
    logic [ROOT_W-1:0]  r_cur, l_cur;
    logic [RECIP_W-1:0] q_cur, q_next;
    meta_t              meta_cur;
    logic               vld_cur;
    logic               nbit;
    logic [ROOT_W:0]    r2;
    logic               ge;

    if (n == 0) begin : g_head
      assign r_cur    = RECIP_SEED;
      assign l_cur    = len;
      assign q_cur    = '0;
      assign meta_cur = len_meta;
      assign vld_cur  = len_valid;
    end else begin : g_tail
      assign r_cur    = r_q[n];
      assign l_cur    = l_q[n];
      assign q_cur    = q_q[n];
      assign meta_cur = meta_q[n];
      assign vld_cur  = vld_q[n];
    end

    // dividend bits below 2^61 are floor(L/2)
    if (J + 1 < ROOT_W) begin : g_bit
      assign nbit = l_cur[J+1];
    end else begin : g_nobit
      assign nbit = 1'b0;
    end

    assign r2 = {r_cur, nbit};
    assign ge = (r2 >= {1'b0, l_cur});

    always_comb begin
      q_next    = q_cur;
      q_next[J] = ge;
    end

    if (n < RECIP_W - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          r_q[n+1] <= ge ? ROOT_W'(r2 - {1'b0, l_cur}) : r2[ROOT_W-1:0];
          l_q[n+1] <= l_cur;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_q[n+1]    <= q_next;
        meta_q[n+1] <= meta_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[n+1] <= 1'b0;
      end else if (en) begin
        vld_q[n+1] <= vld_cur;
      end
    end
  end

  assign recip       = q_q[RECIP_W];
  assign recip_meta  = meta_q[RECIP_W];
  assign recip_valid = vld_q[RECIP_W];

endmodule

// ===== sv/v4n_lane_scale.sv =====
// One component lane, back half: scale by the reciprocal, round, saturate, sign.
// Depends on v4n_pkg.
module v4n_lane_scale import v4n_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [NORM_W-1:0]    norm_mag,
  input  logic                 neg,
  input  logic [RECIP_W-1:0]   recip,
  output logic [UNIT_BITS-1:0] unit
);

  logic [PROD_W-1:0]    prod;
  logic                 neg_q;
  logic [PROD_W-1:0]    rounded;
  logic [U_W-1:0]       u, u_sat, u_neg;
  logic [UNIT_BITS-1:0] unit_next;

  always_comb begin
    rounded = prod + (PROD_W'(1) << (ROUND_POS - 1));
    u       = rounded[PROD_W-1:ROUND_POS];
    if (neg_q) begin
      u_sat = (u > U_MAX_NEG) ? U_MAX_NEG : u;
    end else begin
      u_sat = (u > U_MAX_POS) ? U_MAX_POS : u;
    end
    u_neg     = ~u_sat + U_W'(1);
    unit_next = neg_q ? u_neg[UNIT_BITS-1:0] : u_sat[UNIT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= norm_mag * recip;
      neg_q <= neg;
      unit  <= unit_next;
    end
  end

endmodule

// ===== sv/vector4_normalize.sv =====
// vector4_normalize: four-lane fixed-point vector normalisation. Depends on v4n_pkg.
// Pipeline order: front lanes, merge, root, reciprocal, scale lanes, output buffer.
// Throughput: one vector per cycle while the output buffer has a free entry; the root
// and the reciprocal are fully pipelined at one bit per stage, so items overlap freely.
// Reset (rst, synchronous) empties the pipeline valid bits and the two-entry
// output buffer; datapath registers are not reset.
module vector4_normalize import v4n_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     vec_valid,
  output logic     vec_ready,
  input  vec_in_t  vec_data,
  output logic     res_valid,
  input  logic     res_ready,
  output vec_out_t res_data
);

  logic                                 en;
  logic [LANES-1:0][COMPONENT_BITS-1:0] comp, mag;
  shift_ctrl_t                          ctrl;
  logic [LANES-1:0][NORM_W-1:0]         norm_mag;
  logic [LANES-1:0]                     neg;
  logic [LANES-1:0][SQ_W-1:0]           square;
  logic                                 sum_valid;
  logic [SUM_W-1:0]                     sum;
  meta_t                                sum_meta;
  logic                                 len_valid;
  logic [ROOT_W-1:0]                    len;
  meta_t                                len_meta;
  logic                                 recip_valid;
  logic [RECIP_W-1:0]                   recip;
  meta_t                                recip_meta;
  logic [LANES-1:0][UNIT_BITS-1:0]      unit;
  logic [1:0]                           scale_vld;
  logic [1:0]                           zero_q;
  vec_out_t                             result;
  vec_out_t                             skid [2];
  logic                                 wr_ptr, rd_ptr;
  logic [1:0]                           count, count_next;
  logic                                 push, pop;

  // pipeline moves whenever the output buffer has a free entry
  assign en        = (count < 2'd2);
  assign vec_ready = en;

  assign comp[0] = vec_data.comp_x;
  assign comp[1] = vec_data.comp_y;
  assign comp[2] = vec_data.comp_z;
  assign comp[3] = vec_data.comp_w;

  for (genvar l = 0; l < LANES; l++) begin : g_front
    v4n_lane_front u_front (
      .clk      (clk),
      .en       (en),
      .comp     (comp[l]),
      .mag      (mag[l]),
      .ctrl     (ctrl),
      .norm_mag (norm_mag[l]),
      .neg      (neg[l]),
      .square   (square[l])
    );
  end

  v4n_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .vec_valid (vec_valid),
    .mag       (mag),
    .ctrl      (ctrl),
    .norm_mag  (norm_mag),
    .neg       (neg),
    .square    (square),
    .sum_valid (sum_valid),
    .sum       (sum),
    .sum_meta  (sum_meta)
  );

  v4n_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .sum_valid (sum_valid),
    .sum       (sum),
    .sum_meta  (sum_meta),
    .len_valid (len_valid),
    .len       (len),
    .len_meta  (len_meta)
  );

  v4n_recip u_recip (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .len_valid   (len_valid),
    .len         (len),
    .len_meta    (len_meta),
    .recip_valid (recip_valid),
    .recip       (recip),
    .recip_meta  (recip_meta)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_scale
    v4n_lane_scale u_scale (
      .clk      (clk),
      .en       (en),
      .norm_mag (recip_meta.mag[l]),
      .neg      (recip_meta.neg[l]),
      .recip    (recip),
      .unit     (unit[l])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_q <= {zero_q[0], recip_meta.zero};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_vld <= '0;
    end else if (en) begin
      scale_vld <= {scale_vld[0], recip_valid};
    end
  end

  always_comb begin
    result.unit_x      = unit[0];
    result.unit_y      = unit[1];
    result.unit_z      = unit[2];
    result.unit_w      = unit[3];
    result.zero_length = zero_q[1];
  end

  // two-entry output buffer
  assign push       = en && scale_vld[1];
  assign pop        = res_valid && res_ready;
  assign count_next = count + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (push) begin
      skid[wr_ptr] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count_next;
    end
  end

  assign res_valid = (count != '0);
  assign res_data  = skid[rd_ptr];

endmodule

// ===== sv/v4n_checker.sv =====
// Port-level checks for vector4_normalize, attached to it by the bind below.
// Depends on v4n_pkg and the top-level port list.
module v4n_checker import v4n_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     vec_ready,
  input logic     res_valid,
  input logic     res_ready,
  input vec_out_t res_data
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result transaction changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid straight after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> vec_ready)
    else $error("input stalled with an empty output buffer");

  a_zero_units: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.zero_length |->
      res_data.unit_x == '0 && res_data.unit_y == '0 &&
      res_data.unit_z == '0 && res_data.unit_w == '0)
    else $error("zero-length result with non-zero components");

  a_unit_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.zero_length |->
      res_data.unit_x != '0 || res_data.unit_y != '0 ||
      res_data.unit_z != '0 || res_data.unit_w != '0)
    else $error("non-zero vector normalised to all zeros");

endmodule

bind vector4_normalize v4n_checker u_v4n_checker (.*);
